>>> rtl/core/igdt_pkg.sv
// Shared constants, types and helpers for the grouped decimal text formatter.
package igdt_pkg;

  localparam int VALUE_W    = 64;
  localparam int MAX_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
  localparam int STEP_W     = $clog2(VALUE_W);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CHAR_W     = 8;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [CHAR_W-1:0] SEPARATOR_RESET = 8'd46;
  localparam logic [CHAR_W-1:0] MINUS_CODE      = 8'd45;
  localparam logic [CHAR_W-1:0] ZERO_CODE       = 8'd48;

  // register index (word address)
  localparam logic [ADDR_W-3:0] REG_GROUP_SEPARATOR = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic done;
    logic negative;
  } conv_status_t;

  // remainder by three of a digit count, by restoring subtraction
  function automatic logic [1:0] mod3(input logic [CNT_W-1:0] v);
    logic [CNT_W+1:0] r;
    logic [CNT_W+1:0] m;
    r = {2'b00, v};
    for (int s = CNT_W - 1; s >= 0; s--) begin
      m = (CNT_W + 2)'(3) << s;
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[1:0];
  endfunction

endpackage

>>> rtl/core/igdt_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module igdt_bcd_conv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [igdt_pkg::VALUE_W-1:0] value,
  output igdt_pkg::conv_status_t       status,
  output logic [igdt_pkg::BCD_W-1:0]   bcd
);
  import igdt_pkg::*;

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [VALUE_W-1:0] mag;
  logic               negative;
  logic [BCD_W-1:0]   bcd_adj;
  logic               last_step;

  assign last_step = busy && (step == STEP_W'(VALUE_W - 1));

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (last_step) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      negative <= value[VALUE_W-1];
      mag      <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
      bcd      <= '0;
    end else if (busy) begin
      mag <= {mag[VALUE_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
    end
  end

  assign status.done     = last_step;
  assign status.negative = negative;

endmodule

>>> rtl/core/integer_to_grouped_decimal_text.sv
// Top level: signed 64-bit integer to grouped decimal ASCII text stream.
//
//  channel | direction | beat contents
//  --------+-----------+-----------------------------------------------
//  s_*     | in        | tdata[63:0] value (signed)
//  m_*     | out       | tdata[7:0] text_char, tlast = last_char
//  apb     | in/out    | reg 0 @0x0: group_separator[7:0], reset 0x2E
//
// Steps: a load, 64 conversion steps (the bit-serial shift/add-3 loop in
// igdt_bcd_conv sets this), a sizing step, then one character per cycle
// while the output is not stalled.
// s_tready is high only while idle; a last beat may still wait in the output
// register while the next value is taken.
// Output stalls hold the emission sequencer; reset is synchronous, active high.
module integer_to_grouped_decimal_text (
  input  logic                         clk,
  input  logic                         rst,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [igdt_pkg::VALUE_W-1:0] s_tdata,  // [63:0] value
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [igdt_pkg::CHAR_W-1:0]  m_tdata,  // [7:0] text_char
  output logic                         m_tlast,  // last_char
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [igdt_pkg::ADDR_W-1:0]  paddr,
  input  logic [igdt_pkg::DATA_W-1:0]  pwdata,
  output logic [igdt_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import igdt_pkg::*;

  state_t             state, state_next;
  conv_status_t       conv;
  logic [BCD_W-1:0]   bcd;
  logic [CHAR_W-1:0]  group_separator;

  // emission sequencer
  logic [CNT_W-1:0]   remaining, remaining_next;  // digits still to emit
  logic [1:0]         grp, grp_next;              // remaining mod 3
  logic               sign_pend, sign_pend_next;
  logic               sep_done, sep_done_next;    // separator already sent
  logic               first, first_next;          // no digit sent yet

  logic               out_free;
  logic               emit;
  logic [CHAR_W-1:0]  emit_char;
  logic               emit_last;
  logic [CNT_W-1:0]   digit_count;
  logic [IDX_W-1:0]   digit_idx;
  logic [DIGIT_W-1:0] cur_digit;
  logic               in_beat;
  logic               cfg_wr;

  assign in_beat  = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  igdt_bcd_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (in_beat),
    .value  (s_tdata),
    .status (conv),
    .bcd    (bcd)
  );

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_separator <= SEPARATOR_RESET;
    end else if (cfg_wr && (paddr[ADDR_W-1:2] == REG_GROUP_SEPARATOR)) begin
      group_separator <= pwdata[CHAR_W-1:0];
    end
  end

  assign prdata = (paddr[ADDR_W-1:2] == REG_GROUP_SEPARATOR) ?
                  {{(DATA_W-CHAR_W){1'b0}}, group_separator} : '0;

  // ---- digit count: highest nonzero digit, at least one digit ----
  always_comb begin
    digit_count = CNT_W'(1);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        digit_count = CNT_W'(i + 1);
      end
    end
  end

  // most significant remaining digit
  assign digit_idx = IDX_W'(remaining - CNT_W'(1));
  assign cur_digit = bcd[digit_idx*DIGIT_W +: DIGIT_W];

  // ---- next state and emission ----
  always_comb begin
    state_next     = state;
    remaining_next = remaining;
    grp_next       = grp;
    sign_pend_next = sign_pend;
    sep_done_next  = sep_done;
    first_next     = first;
    emit           = 1'b0;
    emit_char      = ZERO_CODE + CHAR_W'(cur_digit);
    emit_last      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv.done) begin
          state_next = ST_SIZE;
        end
      end
      ST_SIZE: begin
        remaining_next = digit_count;
        grp_next       = mod3(digit_count);
        sign_pend_next = conv.negative;
        sep_done_next  = 1'b0;
        first_next     = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          priority if (sign_pend) begin
            emit_char      = MINUS_CODE;
            sign_pend_next = 1'b0;
          end else if (!first && (grp == 2'd0) && !sep_done) begin
            // group boundary counted over digits only
            emit_char     = group_separator;
            sep_done_next = 1'b1;
          end else begin
            emit_last      = (remaining == CNT_W'(1));
            remaining_next = remaining - CNT_W'(1);
            grp_next       = (grp == 2'd0) ? 2'd2 : grp - 2'd1;
            first_next     = 1'b0;
            sep_done_next  = 1'b0;
            if (remaining == CNT_W'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remaining <= '0;
      grp       <= '0;
      sign_pend <= 1'b0;
      sep_done  <= 1'b0;
      first     <= 1'b0;
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
      grp       <= grp_next;
      sign_pend <= sign_pend_next;
      sep_done  <= sep_done_next;
      first     <= first_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_char;
      m_tlast <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == ST_CONV))
    else $error("accepted value did not start conversion");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv.done |-> (state == ST_CONV))
    else $error("conversion finished outside conversion state");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (remaining != '0))
    else $error("emitting with no digits left");

  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    sign_pend |-> first)
    else $error("sign pending after a digit was sent");

  // a held last beat belongs to the previous value: no digit of this one yet
  a_last_before_digits: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && (state == ST_EMIT)) |-> first)
    else $error("last character held after digits of the next value");
`endif

endmodule
